FILE: rtl/core/sky_pkg.sv
// skyline unit package: controller states and command/status structs
// no dependencies
`timescale 1ns / 1ps
package sky_pkg;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_BUILD,
      ST_PASS_START,
      ST_RUN_START,
      ST_RD,
      ST_WAIT,
      ST_STEP,
      ST_RUN_END,
      ST_PASS_END,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic load;        // store building word
      logic build_init;  // reset build counters
      logic build_step;  // convert one building
      logic pass_init;   // reset pass pointers
      logic run_init;    // set up next run pair
      logic rd;          // issue memory reads
      logic step;        // one merge step
      logic run_end;     // close run
      logic pass_end;    // swap buffers
      logic emit_init;   // reset emit pointer
      logic emit_rd;     // issue emit read
      logic emit_adv;    // advance emit pointer
      logic clear;       // end of set
   } cmd_type;

   typedef struct packed {
      logic build_done;
      logic pass_done;   // all runs of this pass handled
      logic merge_done;  // at most one run left
      logic run_done;    // both lists consumed
      logic emit_last;
      logic empty;
   } status_type;

endpackage

FILE: rtl/core/sky_datapath.sv
// skyline unit datapath: building store, ping-pong point stores, merge sweep
// depends on sky_pkg
`timescale 1ns / 1ps
module sky_datapath #(
   parameter int MAX_BUILDINGS = 32,
   parameter int COORD_BITS    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sky_pkg::cmd_type       cmd,
   output sky_pkg::status_type    status,
   input  logic [15:0]            req_left_x,
   input  logic [15:0]            req_height,
   input  logic [15:0]            req_right_x,
   output logic [15:0]            pt_x,
   output logic [15:0]            pt_h,
   output logic                   pt_trunc
);
   import sky_pkg::*;

   localparam int NB  = MAX_BUILDINGS;
   localparam int NP  = 2 * MAX_BUILDINGS;
   localparam int BW  = $clog2(NB + 1);
   localparam int BI  = (NB > 1) ? $clog2(NB) : 1;
   localparam int PW  = $clog2(NP + 1);
   localparam int PI  = $clog2(NP);
   localparam int CW  = COORD_BITS;
   localparam int EW  = CW + 16;

   logic [2*CW+15:0] bstore [NB];
   logic [EW-1:0]    mem_a [NP];
   logic [EW-1:0]    mem_b [NP];
   logic [PW-1:0]    lens_ff [NB];

   logic [BW-1:0] count_ff;
   logic          ovf_ff;
   logic          sel_ff;       // 0: source is a
   logic [BW-1:0] k_ff;         // building / run index
   logic [BW-1:0] m_ff;         // output run count
   logic [BW-1:0] nruns_ff;
   logic [PW-1:0] total_ff;
   logic [PW-1:0] rpos_ff, wpos_ff;
   logic [PW-1:0] i_ff, j_ff, np_ff, nq_ff, n_ff, qbase_ff;
   logic [15:0]   hp_ff, hq_ff, cur_ff;
   logic [2*CW+15:0] brd_ff;
   logic [EW-1:0] pa_ff, pb_ff;
   logic [PW-1:0] e_ff;

   // building store and count
   always_ff @(posedge clock) begin
      if (cmd.load && count_ff < BW'(NB))
         bstore[count_ff[BI-1:0]] <= {CW'(req_left_x), req_height, CW'(req_right_x)};
      brd_ff <= bstore[k_ff[BI-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.load) begin
         if (count_ff < BW'(NB)) count_ff <= count_ff + 1'b1;
         else ovf_ff <= 1'b1;
      end
   end

   logic [CW-1:0] b_l, b_r;
   logic [15:0]   b_h;
   logic          b_ok;
   assign b_l  = brd_ff[2*CW+15:CW+16];
   assign b_h  = brd_ff[CW+15:CW];
   assign b_r  = brd_ff[CW-1:0];
   assign b_ok = (b_r > b_l) && (b_h != 16'd0);

   // merge selection
   logic [EW-1:0] p_pt, q_pt;
   logic          i_live, j_live, take_p, take_q;
   logic [CW-1:0] px, qx, wx;
   logic [15:0]   nhp, nhq, top;
   assign p_pt   = pa_ff;
   assign q_pt   = pb_ff;
   assign px     = p_pt[EW-1:16];
   assign qx     = q_pt[EW-1:16];
   assign i_live = i_ff < np_ff;
   assign j_live = j_ff < nq_ff;
   always_comb begin
      take_p = 1'b0;
      take_q = 1'b0;
      if (!j_live || (i_live && px < qx)) take_p = 1'b1;
      else if (!i_live || qx < px) take_q = 1'b1;
      else begin
         take_p = 1'b1;
         take_q = 1'b1;
      end
      wx  = take_p ? px : qx;
      nhp = take_p ? p_pt[15:0] : hp_ff;
      nhq = take_q ? q_pt[15:0] : hq_ff;
      top = (nhp > nhq) ? nhp : nhq;
   end

   logic [PW-1:0] ra_addr, rb_addr, w_addr;
   logic          w_en;
   logic [EW-1:0] w_data;
   always_comb begin
      ra_addr = rpos_ff + i_ff;
      rb_addr = qbase_ff + j_ff;
      if (cmd.emit_rd) ra_addr = e_ff;
      w_en   = 1'b0;
      w_addr = wpos_ff + n_ff;
      w_data = {wx, top};
      if (cmd.build_step && b_ok) begin
         w_en   = 1'b1;
         w_addr = total_ff;
         w_data = {b_l, b_h};
      end else if (cmd.step && top != cur_ff) begin
         w_en = 1'b1;
      end
   end

   // second build point written from a hold register the next cycle
   logic          bpend_ff;
   logic [EW-1:0] bhold_ff;
   always_ff @(posedge clock) begin
      bpend_ff <= cmd.build_step && b_ok;
      bhold_ff <= {b_r, 16'd0};
   end

   logic wr_a, wr_b;
   logic [PW-1:0] waddr2;
   logic [EW-1:0] wdata2;
   always_comb begin
      waddr2 = w_addr;
      wdata2 = w_data;
      if (bpend_ff) begin
         waddr2 = total_ff - 1'b1;
         wdata2 = bhold_ff;
      end
      wr_a = (w_en || bpend_ff) && (bpend_ff || cmd.build_step ? 1'b1 : sel_ff);
      wr_b = (w_en || bpend_ff) && !(bpend_ff || cmd.build_step) && !sel_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_a) mem_a[waddr2[PI-1:0]] <= wdata2;
      if (wr_b) mem_b[waddr2[PI-1:0]] <= wdata2;
      pa_ff <= sel_ff ? mem_b[ra_addr[PI-1:0]] : mem_a[ra_addr[PI-1:0]];
      pb_ff <= sel_ff ? mem_b[rb_addr[PI-1:0]] : mem_a[rb_addr[PI-1:0]];
   end

   // building and pass control
   logic has_q;
   logic [PW-1:0] lk, lk1;
   assign lk    = lens_ff[k_ff[BI-1:0]];
   assign has_q = (k_ff + 1'b1) < nruns_ff;
   assign lk1   = has_q ? lens_ff[BI'(k_ff + 1'b1)] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         if (cmd.build_init) sel_ff <= 1'b0;
         else if (cmd.pass_end) sel_ff <= !sel_ff;
      end
      if (cmd.build_init) begin
         k_ff     <= '0;
         total_ff <= '0;
         nruns_ff <= count_ff;
      end
      if (cmd.build_step) begin
         lens_ff[k_ff[BI-1:0]] <= b_ok ? PW'(2) : '0;
         if (b_ok) total_ff <= total_ff + PW'(2);
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.pass_init) begin
         k_ff    <= '0;
         m_ff    <= '0;
         rpos_ff <= '0;
         wpos_ff <= '0;
      end
      if (cmd.run_init) begin
         i_ff     <= '0;
         j_ff     <= '0;
         n_ff     <= '0;
         np_ff    <= lk;
         nq_ff    <= lk1;
         qbase_ff <= rpos_ff + lk;
         hp_ff    <= '0;
         hq_ff    <= '0;
         cur_ff   <= '0;
      end
      if (cmd.step) begin
         hp_ff <= nhp;
         hq_ff <= nhq;
         if (take_p) i_ff <= i_ff + 1'b1;
         if (take_q) j_ff <= j_ff + 1'b1;
         if (top != cur_ff) begin
            cur_ff <= top;
            n_ff   <= n_ff + 1'b1;
         end
      end
      if (cmd.run_end) begin
         lens_ff[m_ff[BI-1:0]] <= n_ff;
         m_ff    <= m_ff + 1'b1;
         wpos_ff <= wpos_ff + n_ff;
         rpos_ff <= rpos_ff + np_ff + nq_ff;
         k_ff    <= k_ff + BW'(2);
      end
      if (cmd.pass_end) nruns_ff <= m_ff;
      if (cmd.emit_init) begin
         e_ff     <= '0;
         total_ff <= (nruns_ff != '0) ? lens_ff[0] : '0;
      end
      if (cmd.emit_adv) e_ff <= e_ff + 1'b1;
   end

   // a lone trailing run is copied by the same sweep: every point of a
   // normalised skyline changes height, so the merge keeps all of them
   assign status.build_done = (k_ff == count_ff);
   assign status.pass_done  = (k_ff >= nruns_ff);
   assign status.merge_done = (nruns_ff <= BW'(1));
   assign status.run_done   = !i_live && !j_live;
   assign status.emit_last  = (e_ff + 1'b1 == total_ff);
   assign status.empty      = (total_ff == '0);

   assign pt_x     = 16'(pa_ff[EW-1:16]);
   assign pt_h     = pa_ff[15:0];
   assign pt_trunc = ovf_ff;

endmodule

FILE: rtl/core/sky_ctrl.sv
// skyline unit controller: load, build, merge passes and emit sequencing
// depends on sky_pkg
`timescale 1ns / 1ps
module sky_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_last,
   output sky_pkg::cmd_type       cmd,
   input  sky_pkg::status_type    status
);
   import sky_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rsp_last  = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            cmd.build_init = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            // build read latency
            if (status.build_done) state_in = ST_PASS_START;
            else state_in = ST_WAIT;
         end
         ST_WAIT: begin
            cmd.build_step = 1'b1;
            state_in = ST_RD;
         end
         ST_PASS_START: begin
            if (status.merge_done) state_in = ST_EMIT_RD;
            else begin
               cmd.pass_init = 1'b1;
               state_in = ST_RUN_START;
            end
         end
         ST_RUN_START: begin
            if (status.pass_done) begin
               cmd.pass_end = 1'b1;
               state_in = ST_PASS_END;
            end else begin
               cmd.run_init = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.run_done) begin
               cmd.run_end = 1'b1;
               state_in = ST_RUN_END;
            end else begin
               cmd.rd = 1'b1;
               state_in = ST_EMIT_WAIT;
            end
         end
         ST_EMIT_WAIT: begin
            // merge read data valid
            cmd.step = 1'b1;
            state_in = ST_STEP;
         end
         ST_RUN_END: state_in = ST_RUN_START;
         ST_PASS_END: state_in = ST_PASS_START;
         ST_EMIT_RD: begin
            cmd.emit_init = 1'b1;
            state_in = ST_EMPTY;
         end
         ST_EMPTY: begin
            if (status.empty) begin
               rsp_valid = 1'b1;
               rsp_last  = 1'b1;
               if (!rsp_stall) begin
                  cmd.clear = 1'b1;
                  state_in = ST_LOAD;
               end
            end else begin
               cmd.emit_rd = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last  = status.emit_last;
            cmd.emit_rd = 1'b1;
            if (!rsp_stall) begin
               cmd.emit_adv = 1'b1;
               cmd.emit_rd  = 1'b0;
               if (status.emit_last) begin
                  cmd.clear = 1'b1;
                  state_in = ST_LOAD;
               end else state_in = ST_EMPTY;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

endmodule

FILE: rtl/core/skyline_from_buildings_unit.sv
// skyline unit top level: joins controller and datapath
// depends on sky_pkg, sky_ctrl, sky_datapath
//
// Buildings arrive one word per cycle on req_ while in the load phase;
// req_last_building closes the set. Beyond MAX_BUILDINGS words are dropped
// and every point of that set is flagged truncated.
// The skyline is then formed by bottom-up pairwise merge passes over two
// ping-pong point memories; each merge step is a registered read, then a
// compare and write; the single shared merge sweep serves every run of every
// pass. Points leave on rsp_ one at a time, each from a registered read; a
// stall on rsp_stall holds the word until taken. req_stall stays high from
// the closing building until the last point is taken. Reset (synchronous)
// empties the set and returns to the load phase.
`timescale 1ns / 1ps
module skyline_from_buildings_unit #(
   parameter int MAX_BUILDINGS = 32,
   parameter int COORD_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_left_x,
   input  logic [15:0] req_height,
   input  logic [15:0] req_right_x,
   input  logic        req_last_building,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_point_x,
   output logic [15:0] rsp_point_height,
   output logic        rsp_last_point,
   output logic        rsp_truncated
);
   import sky_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [15:0] pt_x, pt_h;
   logic        pt_trunc, last_pt;

   sky_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last_building),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_last  (last_pt),
      .cmd       (cmd),
      .status    (status)
   );

   sky_datapath #(
      .MAX_BUILDINGS (MAX_BUILDINGS),
      .COORD_BITS    (COORD_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_left_x  (req_left_x),
      .req_height  (req_height),
      .req_right_x (req_right_x),
      .pt_x        (pt_x),
      .pt_h        (pt_h),
      .pt_trunc    (pt_trunc)
   );

   assign rsp_point_x      = status.empty ? 16'd0 : pt_x;
   assign rsp_point_height = status.empty ? 16'd0 : pt_h;
   assign rsp_last_point   = last_pt;
   assign rsp_truncated    = pt_trunc;

endmodule
